// ===== hw/rtl/stmu_pkg.sv =====
package stmu_pkg;

  // Default number of pending timers
  localparam int unsigned MaxTimersDefault = 16;

  // Field widths
  localparam int unsigned NowW    = 63;
  localparam int unsigned RelW    = 31;
  localparam int unsigned TagW    = 8;
  localparam int unsigned ExpW    = 64;
  localparam int unsigned DelayW  = 31;

  localparam logic [DelayW-1:0] DelayMax = {DelayW{1'b1}};

  // Command codes
  localparam logic CmdSet    = 1'b0;
  localparam logic CmdExpire = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIRED  = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    logic              cmd;
    logic [NowW-1:0]   now_ms;
    logic [RelW-1:0]   rel_timeout;
    logic [TagW-1:0]   callback_tag;
    logic              has_callback;
  } in_word_t;

  typedef struct packed {
    kind_e             kind;
    logic [TagW-1:0]   fired_tag;
    logic [DelayW-1:0] delay_ms;
    logic              last;
  } out_word_t;

  // One queue entry
  typedef struct packed {
    logic [ExpW-1:0] expiry;
    logic [TagW-1:0] tag;
    logic            flag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REJECT,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_ARM_SUB,
    ST_ARM_OUT,
    ST_FIN
  } state_e;

endpackage

// ===== hw/rtl/software_timer_multiplexer_unit.sv =====
// Sorted timer queue feeding one hardware timer.
// Input: drive item_i and raise start; the word is taken at a clock edge where
// start is high and busy is low. busy stays high until the word's work is done.
// Output: each result word is on result_o for one cycle with out_valid_o high;
// the receiver cannot hold results off. The final word of an item has last set.
// A set word walks the queue from its tail through ST_INS_RD and ST_INS_CMP
// for each entry it compares, moving later entries up one place; a full
// queue is rejected through ST_REJECT. An expiry word passes ST_EXP_RD and
// ST_EXP_CMP per removed timer, then ST_EXP_RD and ST_FIN when the queue ends
// empty, or ST_EXP_RD, ST_EXP_CMP, ST_ARM_SUB and ST_ARM_OUT when it reports
// the arm delay. The walk is bound by the queue memory's registered read port
// and its write port (one read and one write per cycle). Results appear in the
// cycle after the state that produces them; the next word may be accepted in
// the same cycle as the final result.
// Reset empties the queue (count and head pointer cleared); entry contents
// are left as they are and are only read below the count.
module software_timer_multiplexer_unit #(
  parameter int unsigned MAX_TIMERS = stmu_pkg::MaxTimersDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  stmu_pkg::in_word_t  item_i,
  output logic                out_valid_o,
  output stmu_pkg::out_word_t result_o
);

  localparam int unsigned IdxW = $clog2(MAX_TIMERS);
  localparam int unsigned CntW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned SumW = CntW + 1;

  stmu_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic             pend_v_q, pend_v_d;
  logic [stmu_pkg::TagW-1:0] pend_tag_q, pend_tag_d;
  logic [stmu_pkg::ExpW-1:0] diff_q, diff_d;

  stmu_pkg::in_word_t         item_q;
  logic [stmu_pkg::ExpW-1:0]  exp_q;

  logic                       emit;
  stmu_pkg::out_word_t        emit_word;
  logic                       out_valid_q;
  stmu_pkg::out_word_t        result_q;

  logic                       wr_en;
  logic [IdxW-1:0]            wr_addr;
  stmu_pkg::entry_t           wr_data;
  logic [IdxW-1:0]            rd_addr;
  stmu_pkg::entry_t           rd_data;
  stmu_pkg::entry_t           new_entry;

  logic accept;

  // Map a queue position onto a memory address
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] pos);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(pos);
    if (sum >= SumW'(MAX_TIMERS)) begin
      sum = sum - SumW'(MAX_TIMERS);
    end
    return sum[IdxW-1:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_q != stmu_pkg::ST_IDLE);
  assign new_entry = '{expiry: exp_q, tag: item_q.callback_tag, flag: item_q.has_callback};

  stmu_queue_mem #(
    .Depth(MAX_TIMERS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Capture the input word and its absolute expiry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      exp_q  <= {1'b0, item_i.now_ms} + stmu_pkg::ExpW'(item_i.rel_timeout);
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stmu_pkg::ST_IDLE;
      count_q  <= '0;
      head_q   <= '0;
      pos_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      head_q   <= head_d;
      pos_q    <= pos_d;
      pend_v_q <= pend_v_d;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    pend_tag_q <= pend_tag_d;
    diff_q     <= diff_d;
  end

  // Sequence the queue walk and the result words
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    pos_d      = pos_q;
    pend_v_d   = pend_v_q;
    pend_tag_d = pend_tag_q;
    diff_d     = diff_q;
    emit       = 1'b0;
    emit_word  = '{kind: stmu_pkg::KIND_FIRED, fired_tag: '0, delay_ms: '0, last: 1'b0};
    wr_en      = 1'b0;
    wr_addr    = head_q;
    wr_data    = new_entry;
    rd_addr    = head_q;

    case (state_q)
      stmu_pkg::ST_IDLE: begin
        if (accept) begin
          pend_v_d = 1'b0;
          if (item_i.cmd == stmu_pkg::CmdSet) begin
            if (count_q == CntW'(MAX_TIMERS)) begin
              state_d = stmu_pkg::ST_REJECT;
            end else begin
              pos_d   = count_q;
              state_d = stmu_pkg::ST_INS_RD;
            end
          end else begin
            state_d = stmu_pkg::ST_EXP_RD;
          end
        end
      end

      stmu_pkg::ST_REJECT: begin
        emit           = 1'b1;
        emit_word.kind = stmu_pkg::KIND_REJECT;
        emit_word.last = 1'b1;
        state_d        = stmu_pkg::ST_IDLE;
      end

      // Place the new timer at the front, or fetch the entry before the slot
      stmu_pkg::ST_INS_RD: begin
        if (pos_q == '0) begin
          wr_en              = 1'b1;
          wr_addr            = phys(head_q, '0);
          count_d            = count_q + 1'b1;
          emit               = 1'b1;
          emit_word.kind     = stmu_pkg::KIND_ARM;
          emit_word.delay_ms = item_q.rel_timeout;
          emit_word.last     = 1'b1;
          state_d            = stmu_pkg::ST_IDLE;
        end else begin
          rd_addr = phys(head_q, pos_q - 1'b1);
          state_d = stmu_pkg::ST_INS_CMP;
        end
      end

      // Stop behind an entry that is not later, otherwise shift it up
      stmu_pkg::ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, pos_q);
        if (rd_data.expiry <= exp_q) begin
          count_d = count_q + 1'b1;
          state_d = stmu_pkg::ST_IDLE;
        end else begin
          wr_data = rd_data;
          pos_d   = pos_q - 1'b1;
          state_d = stmu_pkg::ST_INS_RD;
        end
      end

      stmu_pkg::ST_EXP_RD: begin
        rd_addr = head_q;
        if (count_q == '0) begin
          state_d = stmu_pkg::ST_FIN;
        end else begin
          state_d = stmu_pkg::ST_EXP_CMP;
        end
      end

      // Drop an expired head; delay its fired word until the next one is known
      stmu_pkg::ST_EXP_CMP: begin
        if (rd_data.expiry <= {1'b0, item_q.now_ms}) begin
          head_d  = phys(head_q, CntW'(1));
          count_d = count_q - 1'b1;
          if (rd_data.flag) begin
            if (pend_v_q) begin
              emit                = 1'b1;
              emit_word.fired_tag = pend_tag_q;
            end
            pend_v_d   = 1'b1;
            pend_tag_d = rd_data.tag;
          end
          state_d = stmu_pkg::ST_EXP_RD;
        end else begin
          diff_d  = rd_data.expiry - {1'b0, item_q.now_ms};
          state_d = stmu_pkg::ST_ARM_SUB;
        end
      end

      stmu_pkg::ST_ARM_SUB: begin
        if (pend_v_q) begin
          emit                = 1'b1;
          emit_word.fired_tag = pend_tag_q;
          pend_v_d            = 1'b0;
        end
        state_d = stmu_pkg::ST_ARM_OUT;
      end

      // Report the remaining delay, saturated
      stmu_pkg::ST_ARM_OUT: begin
        emit           = 1'b1;
        emit_word.kind = stmu_pkg::KIND_ARM;
        emit_word.last = 1'b1;
        if (|diff_q[stmu_pkg::ExpW-1:stmu_pkg::DelayW]) begin
          emit_word.delay_ms = stmu_pkg::DelayMax;
        end else begin
          emit_word.delay_ms = diff_q[stmu_pkg::DelayW-1:0];
        end
        state_d = stmu_pkg::ST_IDLE;
      end

      stmu_pkg::ST_FIN: begin
        if (pend_v_q) begin
          emit                = 1'b1;
          emit_word.fired_tag = pend_tag_q;
          emit_word.last      = 1'b1;
          pend_v_d            = 1'b0;
        end
        state_d = stmu_pkg::ST_IDLE;
      end

      default: begin
        state_d = stmu_pkg::ST_IDLE;
      end
    endcase
  end

  // Register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= emit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TIMERS))
    else $error("pending count above queue depth");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.kind == stmu_pkg::KIND_REJECT) |-> count_q == CntW'(MAX_TIMERS))
    else $error("reject word while queue has room");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.last |-> state_q == stmu_pkg::ST_IDLE)
    else $error("final word while still working");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not raise busy");
`endif

endmodule

// ===== hw/rtl/stmu_queue_mem.sv =====
module stmu_queue_mem #(
  parameter int unsigned Depth = stmu_pkg::MaxTimersDefault
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  stmu_pkg::entry_t           wr_data_i,
  input  logic [$clog2(Depth)-1:0]   rd_addr_i,
  output stmu_pkg::entry_t           rd_data_o
);

  stmu_pkg::entry_t mem_q [Depth];
  stmu_pkg::entry_t rd_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule
